/* sv/xcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared constants, codes and helpers for the XOR checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

  localparam int PAYLOAD_MAX = 64;
  localparam int AW          = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int PLEN_W      = 7;
  localparam int STATS_LEN   = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [2:0] EV_OK       = 3'd0;
  localparam logic [2:0] EV_BAD_CSUM = 3'd1;
  localparam logic [2:0] EV_OVERLONG = 3'd2;
  localparam logic [2:0] EV_EARLY_LF = 3'd3;
  localparam logic [2:0] EV_ILLEGAL  = 3'd4;
  localparam logic [2:0] EV_JUNK     = 3'd5;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SEQ   = 3'd1;
  localparam logic [2:0] PH_COMMA = 3'd2;
  localparam logic [2:0] PH_PAY   = 3'd3;
  localparam logic [2:0] PH_CSHI  = 3'd4;
  localparam logic [2:0] PH_CSLO  = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nib_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [7:0]        seq_number;
    logic [7:0]        frame_checksum;
    logic [7:0]        computed_checksum;
    logic [7:0]        gap_count;
    logic [PLEN_W-1:0] payload_len;
    logic [7:0]        payload_byte;
    logic              last;
    logic [15:0]       junk_count;
    logic [7:0]        junk_last_byte;
    logic [2:0]        parse_phase;
    logic              is_stats_command;
  } res_t;

  function automatic nib_t hex_nibble(input logic [7:0] c);
    nib_t       r;
    logic [7:0] d;
    r = '0;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r.ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'd55;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'd87;
      r.ok = 1'b1;
    end
    r.val = d[3:0];
    return r;
  endfunction

  function automatic logic [7:0] stats_char(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd1:    r = CH_T;
      3'd2:    r = CH_A;
      3'd3:    r = CH_T;
      default: r = CH_S;
    endcase
    return r;
  endfunction

endpackage

/* sv/xor_checked_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_unit
// Parses '$' SS ',' payload '*' HH LF frames, checks the XOR checksum and
// reports good frames (one item per payload byte, a single item for an empty payload) and error events.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  rx      | rx_valid / rx_ready | rx_byte
//  res     | res_valid/res_ready | event_res .. is_stats_command (12 fields)
//
//  A byte is accepted whenever the output register is free and no replay runs.
//  A good frame of N > 0 payload bytes is replayed from the payload RAM after
//  its newline: for each item a RAM read, then an output load.
//  Synchronous reset clears control and parse state; the RAM is not cleared.
//  A stalled output holds the block; no byte is taken during a replay.
module xor_checked_frame_receiver_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [2:0]                 event_res,
  output logic [7:0]                 seq_number,
  output logic [7:0]                 frame_checksum,
  output logic [7:0]                 computed_checksum,
  output logic [7:0]                 gap_count,
  output logic [xcfr_pkg::PLEN_W-1:0] payload_len,
  output logic [7:0]                 payload_byte,
  output logic                       last,
  output logic [15:0]                junk_count,
  output logic [7:0]                 junk_last_byte,
  output logic [2:0]                 parse_phase,
  output logic                       is_stats_command
);
  import xcfr_pkg::*;

  typedef enum logic [1:0] {ST_RUN, ST_RD, ST_WR} st_t;

  st_t              st, st_next;
  logic [2:0]       phase, phase_next;
  logic [7:0]       frame_seq, frame_seq_next;
  logic [7:0]       expected_seq, expected_seq_next;
  logic             expected_valid, expected_valid_next;
  logic             seq_digits, seq_digits_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       carried_checksum, carried_checksum_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic             stats_ok, stats_ok_next;
  logic [15:0]      junk_run, junk_run_next;
  logic [7:0]       junk_last, junk_last_next;
  logic [7:0]       gap_hold, gap_hold_next;
  logic             stats_hold, stats_hold_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_plus;
  res_t             res, res_next;
  logic             res_valid_next;

  logic [7:0]       payload_store [PAYLOAD_MAX];
  logic [7:0]       rd_data;
  logic             mem_we;

  logic             out_free;
  logic             acc;

  assign out_free = !res_valid || res_ready;
  assign rx_ready = (st == ST_RUN) && out_free;
  assign acc      = rx_valid && rx_ready;
  assign idx_plus = idx + 1'b1;

  always_comb begin
    res_t       r;
    nib_t       nib;
    logic       emit;
    logic       do_drop;
    logic       do_begin;
    logic [7:0] gap;
    r        = '0;
    nib      = hex_nibble(rx_byte);
    emit     = 1'b0;
    do_drop  = 1'b0;
    do_begin = 1'b0;
    gap      = 8'h00;

    st_next               = st;
    phase_next            = phase;
    frame_seq_next        = frame_seq;
    expected_seq_next     = expected_seq;
    expected_valid_next   = expected_valid;
    seq_digits_next       = seq_digits;
    running_xor_next      = running_xor;
    carried_checksum_next = carried_checksum;
    payload_count_next    = payload_count;
    stats_ok_next         = stats_ok;
    junk_run_next         = junk_run;
    junk_last_next        = junk_last;
    gap_hold_next         = gap_hold;
    stats_hold_next       = stats_hold;
    idx_next              = idx;
    res_next              = res;
    res_valid_next        = res_valid && !res_ready;
    mem_we                = 1'b0;

    case (st)
      ST_RUN: begin
        if (acc) begin
          if (rx_byte == CH_LF && phase != PH_IDLE && phase != PH_END) begin
            emit          = 1'b1;
            r.event_res   = EV_EARLY_LF;
            r.parse_phase = phase;
            r.last        = 1'b1;
            phase_next    = PH_IDLE;
          end else begin
            case (phase)
              PH_IDLE: begin
                if (rx_byte == CH_DOLLAR) begin
                  if (junk_run != '0) begin
                    emit             = 1'b1;
                    r.event_res      = EV_JUNK;
                    r.junk_count     = junk_run;
                    r.junk_last_byte = junk_last;
                    r.last           = 1'b1;
                  end
                  junk_run_next = '0;
                  do_begin      = 1'b1;
                end else if (rx_byte != CH_LF && rx_byte != CH_CR) begin
                  if (junk_run != '1) junk_run_next = junk_run + 16'd1;
                  junk_last_next = rx_byte;
                end
              end
              PH_SEQ: begin
                if (!nib.ok) begin
                  do_drop = 1'b1;
                end else begin
                  running_xor_next = running_xor ^ rx_byte;
                  frame_seq_next   = {frame_seq[3:0], nib.val};
                  if (seq_digits) begin
                    seq_digits_next = 1'b0;
                    phase_next      = PH_COMMA;
                  end else begin
                    seq_digits_next = 1'b1;
                  end
                end
              end
              PH_COMMA: begin
                if (rx_byte != CH_COMMA) begin
                  do_drop = 1'b1;
                end else begin
                  running_xor_next = running_xor ^ rx_byte;
                  phase_next       = PH_PAY;
                end
              end
              PH_PAY: begin
                if (rx_byte == CH_STAR) begin
                  phase_next            = PH_CSHI;
                  carried_checksum_next = 8'h00;
                end else if (32'(payload_count) >= PAYLOAD_MAX) begin
                  emit          = 1'b1;
                  r.event_res   = EV_OVERLONG;
                  r.parse_phase = PH_PAY;
                  r.last        = 1'b1;
                  phase_next    = PH_IDLE;
                end else begin
                  running_xor_next   = running_xor ^ rx_byte;
                  mem_we             = 1'b1;
                  payload_count_next = payload_count + 1'b1;
                  if (32'(payload_count) < STATS_LEN) begin
                    stats_ok_next = stats_ok &&
                                    (rx_byte == stats_char(3'(payload_count)));
                  end
                end
              end
              PH_CSHI: begin
                if (!nib.ok) begin
                  do_drop = 1'b1;
                end else begin
                  carried_checksum_next = {nib.val, 4'h0};
                  phase_next            = PH_CSLO;
                end
              end
              PH_CSLO: begin
                if (!nib.ok) begin
                  do_drop = 1'b1;
                end else begin
                  carried_checksum_next = {carried_checksum[7:4], nib.val};
                  phase_next            = PH_END;
                end
              end
              PH_END: begin
                if (rx_byte != CH_LF) begin
                  do_drop = 1'b1;
                end else begin
                  if (carried_checksum != running_xor) begin
                    emit                = 1'b1;
                    r.event_res         = EV_BAD_CSUM;
                    r.seq_number        = frame_seq;
                    r.frame_checksum    = carried_checksum;
                    r.computed_checksum = running_xor;
                    r.last              = 1'b1;
                  end else begin
                    if (expected_valid) gap = frame_seq - expected_seq;
                    if (payload_count == '0) begin
                      emit                = 1'b1;
                      r.event_res         = EV_OK;
                      r.seq_number        = frame_seq;
                      r.frame_checksum    = carried_checksum;
                      r.computed_checksum = running_xor;
                      r.gap_count         = gap;
                      r.last              = 1'b1;
                    end else begin
                      gap_hold_next   = gap;
                      stats_hold_next = (32'(payload_count) == STATS_LEN) && stats_ok;
                      idx_next        = '0;
                      st_next         = ST_RD;
                    end
                  end
                  expected_seq_next   = frame_seq + 8'd1;
                  expected_valid_next = 1'b1;
                  phase_next          = PH_IDLE;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end

          if (do_drop) begin
            emit          = 1'b1;
            r.event_res   = EV_ILLEGAL;
            r.parse_phase = phase;
            r.last        = 1'b1;
            if (rx_byte == CH_DOLLAR) do_begin = 1'b1;
            else phase_next = PH_IDLE;
          end
          if (do_begin) begin
            phase_next         = PH_SEQ;
            seq_digits_next    = 1'b0;
            frame_seq_next     = 8'h00;
            running_xor_next   = 8'h00;
            payload_count_next = '0;
            stats_ok_next      = 1'b1;
          end
        end
      end
      ST_RD: st_next = ST_WR;
      ST_WR: begin
        if (out_free) begin
          emit                = 1'b1;
          r.event_res         = EV_OK;
          r.seq_number        = frame_seq;
          r.frame_checksum    = carried_checksum;
          r.computed_checksum = running_xor;
          r.gap_count         = gap_hold;
          r.payload_len       = PLEN_W'(payload_count);
          r.payload_byte      = rd_data;
          r.is_stats_command  = stats_hold;
          r.last              = (idx_plus == payload_count);
          idx_next            = idx_plus;
          st_next             = (idx_plus == payload_count) ? ST_RUN : ST_RD;
        end
      end
      default: st_next = ST_RUN;
    endcase

    if (emit) begin
      res_next       = r;
      res_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) payload_store[payload_count[AW-1:0]] <= rx_byte;
    rd_data <= payload_store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    res              <= res_next;
    gap_hold         <= gap_hold_next;
    stats_hold       <= stats_hold_next;
    idx              <= idx_next;
    if (rst) begin
      st             <= ST_RUN;
      phase          <= PH_IDLE;
      frame_seq      <= 8'h00;
      expected_seq   <= 8'h00;
      expected_valid <= 1'b0;
      seq_digits     <= 1'b0;
      running_xor    <= 8'h00;
      payload_count  <= '0;
      stats_ok       <= 1'b0;
      junk_run       <= '0;
      res_valid      <= 1'b0;
      junk_last        <= 8'h00;
      carried_checksum <= 8'h00;
    end else begin
      st             <= st_next;
      phase          <= phase_next;
      frame_seq      <= frame_seq_next;
      expected_seq   <= expected_seq_next;
      expected_valid <= expected_valid_next;
      seq_digits     <= seq_digits_next;
      running_xor    <= running_xor_next;
      payload_count  <= payload_count_next;
      stats_ok       <= stats_ok_next;
      junk_run       <= junk_run_next;
      res_valid      <= res_valid_next;
      junk_last        <= junk_last_next;
      carried_checksum <= carried_checksum_next;
    end
  end

  assign event_res         = res.event_res;
  assign seq_number        = res.seq_number;
  assign frame_checksum    = res.frame_checksum;
  assign computed_checksum = res.computed_checksum;
  assign gap_count         = res.gap_count;
  assign payload_len       = res.payload_len;
  assign payload_byte      = res.payload_byte;
  assign last              = res.last;
  assign junk_count        = res.junk_count;
  assign junk_last_byte    = res.junk_last_byte;
  assign parse_phase       = res.parse_phase;
  assign is_stats_command  = res.is_stats_command;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (32'(payload_count) <= PAYLOAD_MAX))
    else $error("payload count beyond store depth");

  a_replay_index: assert property (@(posedge clk) disable iff (rst)
    (st != ST_RUN) |-> (idx < payload_count))
    else $error("replay index past payload count");

  a_start_frame: assert property (@(posedge clk) disable iff (rst)
    (acc && phase == PH_IDLE && rx_byte == CH_DOLLAR) |=> (phase == PH_SEQ))
    else $error("start marker did not open a frame");

  a_replay_end: assert property (@(posedge clk) disable iff (rst)
    (st == ST_WR && out_free && idx_plus == payload_count)
      |=> (st == ST_RUN && res_valid && res.last))
    else $error("replay did not close with a last item");

endmodule
